/* rtl/core/crb_pkg.sv */
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types, codes and helpers of the convolution row accumulate block.
// ----------------------------------------------------------------------------
package crb_pkg;

  localparam int unsigned LANES_DEF = 16;
  localparam int unsigned POS_DEF   = 6;
  localparam int unsigned FIELDS    = 6;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_ACCUM  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam logic [1:0] ACTV_NONE  = 2'd0;
  localparam logic [1:0] ACTV_RELU  = 2'd1;
  localparam logic [1:0] ACTV_RELU6 = 2'd2;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_SUM   = 2'd1;
  localparam logic [1:0] REG_ACTV  = 2'd2;

  localparam logic [2:0] WIDTH_RST = 3'd6;

  localparam word_t QNAN32 = 32'h7FC0_0000;
  localparam word_t SIX32  = 32'h40C0_0000;
  localparam word_t ONE32  = 32'h3F80_0000;
  localparam word_t INF32  = 32'h7F80_0000;

  typedef struct packed {
    logic [2:0] width;
    logic       sum_en;
    logic [1:0] actv;
  } cfg_t;

  typedef struct packed {
    action_e                action;
    logic [3:0]             lane;
    word_t                  weight;
    word_t [FIELDS-1:0]     values;
  } cmd_t;

  function automatic word_t activate(word_t v, logic [1:0] actv);
    word_t r;
    r = v;
    if (actv != ACTV_NONE) begin
      if (r[30:0] > INF32[30:0] || r[31]) begin
        r = '0;
      end
      if (actv[1] && r > SIX32) begin
        r = SIX32;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/crb_front.sv */
// ----------------------------------------------------------------------------
// crb_front
// Input side: drops items that address no lane or carry no action, and
// queues the rest in a two-word buffer for the back end.
// ----------------------------------------------------------------------------
module crb_front #(
  parameter int unsigned LANES = crb_pkg::LANES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  crb_pkg::cmd_t cmd_i,
  output logic          cmd_valid_o,
  output crb_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);

  crb_pkg::cmd_t buf_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          keep;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];

  assign keep = push && !full && (cmd_i.action != crb_pkg::ACT_NONE) &&
                (32'(cmd_i.lane) < LANES);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (keep) begin
      wr_d = ~wr_q;
    end
    if (cmd_take_i && cmd_valid_o) begin
      rd_d = ~rd_q;
    end
    if (keep && !(cmd_take_i && cmd_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!keep && cmd_take_i && cmd_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      buf_q[wr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/core/crb_fma.sv */
// ----------------------------------------------------------------------------
// crb_fma
// Iterative binary32 fused multiply-add, a * b + c with one rounding,
// round to nearest even, subnormals kept, canonical quiet NaN.
// ----------------------------------------------------------------------------
module crb_fma (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  crb_pkg::word_t       a_i,
  input  crb_pkg::word_t       b_i,
  input  crb_pkg::word_t       c_i,
  output logic                 done_o,
  output crb_pkg::word_t       res_o
);

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_NORM, F_SWAP, F_ALIGN, F_ADD, F_SNORM, F_RND, F_PACK, F_DONE
  } fstate_e;

  fstate_e               state_q;
  crb_pkg::word_t        res_q;
  logic [23:0]           ma_q, mb_q, mc_q;
  logic signed [11:0]    ea_q, eb_q, ec_q;
  logic signed [11:0]    ex_q, ey_q;
  logic [63:0]           x_q, y_q;
  logic                  sx_q, sy_q, czero_q;
  logic [24:0]           m_q;
  logic                  up_q;
  logic signed [11:0]    k_q;

  // special cases and unpacking
  logic [30:0]           aa, ab, ac;
  logic                  sp, sc;
  logic                  special;
  crb_pkg::word_t        spec_res;

  assign aa = a_i[30:0];
  assign ab = b_i[30:0];
  assign ac = c_i[30:0];
  assign sp = a_i[31] ^ b_i[31];
  assign sc = c_i[31];

  always_comb begin
    special  = 1'b1;
    spec_res = crb_pkg::QNAN32;
    if (aa > crb_pkg::INF32[30:0] || ab > crb_pkg::INF32[30:0] ||
        ac > crb_pkg::INF32[30:0]) begin
      spec_res = crb_pkg::QNAN32;
    end else if (aa == crb_pkg::INF32[30:0] || ab == crb_pkg::INF32[30:0]) begin
      if (aa == 31'd0 || ab == 31'd0) begin
        spec_res = crb_pkg::QNAN32;
      end else if (ac == crb_pkg::INF32[30:0] && sc != sp) begin
        spec_res = crb_pkg::QNAN32;
      end else begin
        spec_res = {sp, crb_pkg::INF32[30:0]};
      end
    end else if (ac == crb_pkg::INF32[30:0]) begin
      spec_res = c_i;
    end else if (aa == 31'd0 || ab == 31'd0) begin
      spec_res = (ac == 31'd0) ? {sp & sc, 31'd0} : c_i;
    end else begin
      special = 1'b0;
    end
  end

  // normalising steps
  logic x_ok, y_ok, s_ok;
  assign x_ok = x_q[61];
  assign y_ok = y_q[61] || czero_q;
  assign s_ok = x_q[62];

  // alignment
  logic signed [11:0] d;
  logic [63:0]        y_al;
  assign d = ex_q - ey_q;

  always_comb begin
    y_al = y_q;
    if (d >= 12'sd64) begin
      y_al = 64'd1;
    end else if (d > 12'sd0) begin
      y_al = (y_q >> d[5:0]) | 64'((y_q & ~({64{1'b1}} << d[5:0])) != 64'd0);
    end
  end

  // rounding
  logic signed [11:0] low, shift;
  logic [63:0]        mask, rem, half, mshift;
  always_comb begin
    low    = -12'sd149 - ex_q;
    shift  = (low > 12'sd39) ? low : 12'sd39;
    mask   = (shift == 12'sd64) ? {64{1'b1}} : ~({64{1'b1}} << shift[5:0]);
    rem    = x_q & mask;
    half   = 64'd1 << 6'(shift - 12'sd1);
    mshift = (shift == 12'sd64) ? 64'd0 : (x_q >> shift[5:0]);
  end

  logic [35:0] bits;
  assign bits = {k_q[11:0], 23'd0} + 36'(m_q) + 36'(up_q);

  assign done_o = (state_q == F_DONE);
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      res_q   <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      mc_q    <= '0;
      ea_q    <= '0;
      eb_q    <= '0;
      ec_q    <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      sx_q    <= 1'b0;
      sy_q    <= 1'b0;
      czero_q <= 1'b0;
      m_q     <= '0;
      up_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            if (special) begin
              res_q   <= spec_res;
              state_q <= F_DONE;
            end else begin
              ma_q    <= (a_i[30:23] == 8'd0) ? {1'b0, a_i[22:0]} : {1'b1, a_i[22:0]};
              mb_q    <= (b_i[30:23] == 8'd0) ? {1'b0, b_i[22:0]} : {1'b1, b_i[22:0]};
              mc_q    <= (c_i[30:23] == 8'd0) ? {1'b0, c_i[22:0]} : {1'b1, c_i[22:0]};
              ea_q    <= (a_i[30:23] == 8'd0) ? -12'sd149
                                              : $signed({4'd0, a_i[30:23]}) - 12'sd150;
              eb_q    <= (b_i[30:23] == 8'd0) ? -12'sd149
                                              : $signed({4'd0, b_i[30:23]}) - 12'sd150;
              ec_q    <= (c_i[30:23] == 8'd0) ? -12'sd149
                                              : $signed({4'd0, c_i[30:23]}) - 12'sd150;
              sx_q    <= sp;
              sy_q    <= sc;
              czero_q <= (ac == 31'd0);
              state_q <= F_MUL;
            end
          end
        end
        F_MUL: begin
          x_q     <= 64'(ma_q * mb_q);
          ex_q    <= ea_q + eb_q;
          y_q     <= 64'(mc_q);
          ey_q    <= ec_q;
          state_q <= F_NORM;
        end
        F_NORM: begin
          if (!x_ok) begin
            if (x_q[61:54] == 8'd0) begin
              x_q  <= x_q << 8;
              ex_q <= ex_q - 12'sd8;
            end else begin
              x_q  <= x_q << 1;
              ex_q <= ex_q - 12'sd1;
            end
          end
          if (!y_ok) begin
            if (y_q[61:54] == 8'd0) begin
              y_q  <= y_q << 8;
              ey_q <= ey_q - 12'sd8;
            end else begin
              y_q  <= y_q << 1;
              ey_q <= ey_q - 12'sd1;
            end
          end
          if (x_ok && y_ok) begin
            state_q <= czero_q ? F_SNORM : F_SWAP;
          end
        end
        F_SWAP: begin
          if (ex_q < ey_q || (ex_q == ey_q && x_q < y_q)) begin
            x_q  <= y_q;
            y_q  <= x_q;
            ex_q <= ey_q;
            ey_q <= ex_q;
            sx_q <= sy_q;
            sy_q <= sx_q;
          end
          state_q <= F_ALIGN;
        end
        F_ALIGN: begin
          y_q     <= y_al;
          state_q <= F_ADD;
        end
        F_ADD: begin
          if (sx_q == sy_q) begin
            x_q     <= x_q + y_q;
            state_q <= F_SNORM;
          end else if (x_q == y_q) begin
            res_q   <= '0;
            state_q <= F_DONE;
          end else begin
            x_q     <= x_q - y_q;
            state_q <= F_SNORM;
          end
        end
        F_SNORM: begin
          if (s_ok) begin
            state_q <= F_RND;
          end else if (x_q[62:55] == 8'd0) begin
            x_q  <= x_q << 8;
            ex_q <= ex_q - 12'sd8;
          end else begin
            x_q  <= x_q << 1;
            ex_q <= ex_q - 12'sd1;
          end
        end
        F_RND: begin
          if (shift >= 12'sd65) begin
            res_q   <= {sx_q, 31'd0};
            state_q <= F_DONE;
          end else begin
            m_q     <= mshift[24:0];
            up_q    <= (rem > half) || (rem == half && mshift[0]);
            k_q     <= ex_q + shift + 12'sd149;
            state_q <= F_PACK;
          end
        end
        F_PACK: begin
          if (bits >= 36'(crb_pkg::INF32)) begin
            res_q <= {sx_q, crb_pkg::INF32[30:0]};
          end else begin
            res_q <= {sx_q, bits[30:0]};
          end
          state_q <= F_DONE;
        end
        F_DONE: begin
          state_q <= F_IDLE;
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/crb_back.sv */
// ----------------------------------------------------------------------------
// crb_back
// Back end: reads a lane's accumulator row, steps through its positions with
// the shared fused unit, writes the row back or emits the finished word.
// ----------------------------------------------------------------------------
module crb_back #(
  parameter int unsigned LANES     = crb_pkg::LANES_DEF,
  parameter int unsigned POSITIONS = crb_pkg::POS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  crb_pkg::cfg_t                         cfg_i,
  input  logic                                  cmd_valid_i,
  input  crb_pkg::cmd_t                         cmd_i,
  output logic                                  cmd_take_o,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [3:0]                            out_lane_o,
  output crb_pkg::word_t [crb_pkg::FIELDS-1:0]  result_o
);

  localparam int unsigned LaneW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned Cap   = (POSITIONS < crb_pkg::FIELDS) ? POSITIONS
                                                                 : crb_pkg::FIELDS;

  typedef enum logic [2:0] {B_IDLE, B_OP, B_WAIT, B_WRITE, B_EMIT} bstate_e;

  crb_pkg::word_t [POSITIONS-1:0] mem [LANES];
  crb_pkg::word_t [POSITIONS-1:0] row_q, row_d;

  bstate_e        state_q;
  crb_pkg::cmd_t  cmd_q;
  logic [2:0]     j_q;
  logic           out_valid_q;
  logic [3:0]     out_lane_q;
  crb_pkg::word_t [crb_pkg::FIELDS-1:0] out_q;
  crb_pkg::word_t [crb_pkg::FIELDS-1:0] emit_word;

  logic [2:0]     w;
  crb_pkg::word_t acc_sel, val_sel;
  logic           fma_start, fma_done;
  crb_pkg::word_t fma_a, fma_b, fma_res;
  logic           row_we;
  crb_pkg::word_t row_wdata;
  logic           slot_free;

  always_comb begin
    w = cfg_i.width;
    if (w == 3'd0) begin
      w = 3'd1;
    end else if (w > 3'(Cap)) begin
      w = 3'(Cap);
    end
  end

  always_comb begin
    acc_sel = '0;
    for (int k = 0; k < int'(POSITIONS); k++) begin
      if (3'(k) == j_q) begin
        acc_sel = row_q[k];
      end
    end
    val_sel = '0;
    for (int k = 0; k < int'(crb_pkg::FIELDS); k++) begin
      if (3'(k) == j_q) begin
        val_sel = cmd_q.values[k];
      end
    end
  end

  assign cmd_take_o = (state_q == B_IDLE) && cmd_valid_i;
  assign slot_free  = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_lane_o = out_lane_q;
  assign result_o   = out_q;

  // shared fused unit
  always_comb begin
    fma_start = 1'b0;
    fma_a     = cmd_q.weight;
    fma_b     = val_sel;
    if (state_q == B_OP && j_q < w) begin
      if (cmd_q.action == crb_pkg::ACT_ACCUM) begin
        fma_start = 1'b1;
      end else if (cmd_q.action == crb_pkg::ACT_FINISH && cfg_i.sum_en) begin
        fma_start = 1'b1;
        fma_a     = val_sel;
        fma_b     = crb_pkg::ONE32;
      end
    end
  end

  crb_fma u_fma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fma_start),
    .a_i     (fma_a),
    .b_i     (fma_b),
    .c_i     (acc_sel),
    .done_o  (fma_done),
    .res_o   (fma_res)
  );

  // row update
  always_comb begin
    row_we    = 1'b0;
    row_wdata = fma_res;
    if (state_q == B_OP && j_q < w && cmd_q.action == crb_pkg::ACT_START) begin
      row_we    = 1'b1;
      row_wdata = cmd_q.weight;
    end else if (state_q == B_WAIT && fma_done) begin
      row_we = 1'b1;
    end
    row_d = row_q;
    for (int k = 0; k < int'(POSITIONS); k++) begin
      if (row_we && 3'(k) == j_q) begin
        row_d[k] = row_wdata;
      end
    end
  end

  // finished word, positions beyond the width read as zero
  always_comb begin
    emit_word = '0;
    for (int k = 0; k < int'(Cap); k++) begin
      if (3'(k) < w) begin
        emit_word[k] = crb_pkg::activate(row_q[k], cfg_i.actv);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      row_q <= mem[LaneW'(cmd_i.lane)];
      cmd_q <= cmd_i;
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_WRITE) begin
      mem[LaneW'(cmd_q.lane)] <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      out_lane_q  <= '0;
      out_q       <= '0;
    end else begin
      if (state_q == B_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
        out_lane_q  <= cmd_q.lane;
        out_q       <= emit_word;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          j_q <= '0;
          if (cmd_valid_i) begin
            state_q <= B_OP;
          end
        end
        B_OP: begin
          if (j_q >= w) begin
            state_q <= (cmd_q.action == crb_pkg::ACT_FINISH) ? B_EMIT : B_WRITE;
          end else if (fma_start) begin
            state_q <= B_WAIT;
          end else begin
            j_q <= j_q + 3'd1;
          end
        end
        B_WAIT: begin
          if (fma_done) begin
            j_q     <= j_q + 3'd1;
            state_q <= B_OP;
          end
        end
        B_WRITE: begin
          state_q <= B_IDLE;
        end
        B_EMIT: begin
          if (slot_free) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/conv_row_block_mac_fused_act.sv */
// ----------------------------------------------------------------------------
// conv_row_block_mac_fused_act
// Accumulate core of a direct convolution: per lane bias load, fused
// multiply-add over up to six positions, sum input and activation on finish.
// ----------------------------------------------------------------------------
// start: the back end loads the bias into each position in use; accumulate:
// one fused multiply-add per position in use on the single shared iterative
// fused multiply-add unit; finish: one fused pass per position with sum
// inputs.
// the input queue is registered; a two-word queue decouples push from work.
// reset clears control state and the registers (width 6, sum off, no
// activation); accumulator rows are undefined until a lane is started.
module conv_row_block_mac_fused_act #(
  parameter int unsigned LANES     = crb_pkg::LANES_DEF,
  parameter int unsigned POSITIONS = crb_pkg::POS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [3:0]  lane_i,
  input  logic [31:0] weight_i,
  input  logic [31:0] value0_i,
  input  logic [31:0] value1_i,
  input  logic [31:0] value2_i,
  input  logic [31:0] value3_i,
  input  logic [31:0] value4_i,
  input  logic [31:0] value5_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_lane_o,
  output logic [31:0] result0_o,
  output logic [31:0] result1_o,
  output logic [31:0] result2_o,
  output logic [31:0] result3_o,
  output logic [31:0] result4_o,
  output logic [31:0] result5_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);

  crb_pkg::cfg_t  cfg_q;
  crb_pkg::cmd_t  cmd_in, cmd_q;
  logic           cmd_valid, cmd_take;
  crb_pkg::word_t [crb_pkg::FIELDS-1:0] results;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= crb_pkg::WIDTH_RST;
      cfg_q.sum_en <= 1'b0;
      cfg_q.actv   <= crb_pkg::ACTV_NONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crb_pkg::REG_WIDTH: cfg_q.width  <= cfg_data_i;
        crb_pkg::REG_SUM:   cfg_q.sum_en <= cfg_data_i[0];
        crb_pkg::REG_ACTV:  cfg_q.actv   <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cmd_in.action    = crb_pkg::action_e'(action_i);
    cmd_in.lane      = lane_i;
    cmd_in.weight    = weight_i;
    cmd_in.values[0] = value0_i;
    cmd_in.values[1] = value1_i;
    cmd_in.values[2] = value2_i;
    cmd_in.values[3] = value3_i;
    cmd_in.values[4] = value4_i;
    cmd_in.values[5] = value5_i;
  end

  crb_front #(
    .LANES (LANES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_in),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_q),
    .cmd_take_i  (cmd_take)
  );

  crb_back #(
    .LANES     (LANES),
    .POSITIONS (POSITIONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_q),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .out_lane_o  (out_lane_o),
    .result_o    (results)
  );

  assign result0_o = results[0];
  assign result1_o = results[1];
  assign result2_o = results[2];
  assign result3_o = results[3];
  assign result4_o = results[4];
  assign result5_o = results[5];

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the convolution row accumulate block. A directed
// table covers extremes, every action, NaN, infinity and activation corner
// cases. Random start, accumulate and finish chains then run under several
// register settings and handshake idling patterns. A local binary32 fused
// multiply-add model predicts each finished word that the table does not give,
// and output words are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import crb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLANES  = 16;
  localparam int NPOS    = 6;
  localparam int DRAIN   = 800;
  localparam int LIMIT   = 1000000;
  localparam int HOLD    = 2000;
  localparam word_t NINF32 = 32'hFF80_0000;

  typedef struct {
    logic [3:0] lane;
    word_t      res [NPOS];
  } fin_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [2:0] data;
    action_e    act;
    logic [3:0] lane;
    word_t      wt;
    word_t      vals [NPOS];
    bit         typed;
    word_t      res [NPOS];
  } row_t;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic [1:0]  action_i;
  logic [3:0]  lane_i;
  logic [31:0] weight_i;
  logic [31:0] value_w [NPOS];
  logic [3:0]  out_lane_o;
  logic [31:0] result0_o, result1_o, result2_o, result3_o, result4_o, result5_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [2:0]  cfg_data_i;

  conv_row_block_mac_fused_act dut (
    .clk_i, .rst_ni, .push, .full,
    .action_i, .lane_i, .weight_i,
    .value0_i(value_w[0]), .value1_i(value_w[1]), .value2_i(value_w[2]),
    .value3_i(value_w[3]), .value4_i(value_w[4]), .value5_i(value_w[5]),
    .empty, .pop, .out_lane_o,
    .result0_o, .result1_o, .result2_o, .result3_o, .result4_o, .result5_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor state
  word_t      acc_mem [NLANES][NPOS];
  logic [5:0] written [NLANES];
  logic [2:0] p_width;
  logic       p_sum;
  logic [1:0] p_actv;

  fin_t   pending_q [$];
  row_t   table_q [$];
  int     errors = 0;
  int     n_words = 0;
  int     n_items, n_cfg, n_ignored;
  int     sidle, ridle;
  bit     want_hold;
  int     cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int msb64(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  function automatic word_t fp_round(bit sgn, logic [63:0] s, int e);
    int p, sh, lo;
    logic [63:0] m, rem, half, bits;
    p = msb64(s);
    sh = p - 23;
    lo = -149 - e;
    if (lo > sh) sh = lo;
    if (sh <= 0) begin
      m = s << (-sh);
    end else if (sh >= 65) begin
      return {sgn, 31'b0};
    end else begin
      if (sh == 64) begin
        m = '0; rem = s; half = 64'd1 << 63;
      end else begin
        m = s >> sh;
        rem = s & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
      end
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end
    bits = (64'(e + sh + 149) << 23) + m;
    if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
    return {sgn, bits[30:0]};
  endfunction

  function automatic void fp_split(word_t x, output logic [63:0] m, output int e);
    if (x[30:23] == 8'd0) begin
      m = 64'(x[22:0]); e = -149;
    end else begin
      m = 64'({1'b1, x[22:0]}); e = int'(x[30:23]) - 150;
    end
  endfunction

  // a * b + c, one rounding
  function automatic word_t fp_fma(word_t a, word_t b, word_t c);
    word_t aa, ab, ac;
    bit sp, sc, sx, sy, ts;
    logic [63:0] ma, mb, mc, x, y, s, t;
    int ea, eb, ec, ex, ey, d, te;
    aa = {1'b0, a[30:0]}; ab = {1'b0, b[30:0]}; ac = {1'b0, c[30:0]};
    sp = a[31] ^ b[31]; sc = c[31];
    if (aa > INF32 || ab > INF32 || ac > INF32) return QNAN32;
    if (aa == INF32 || ab == INF32) begin
      if (aa == 0 || ab == 0) return QNAN32;
      if (ac == INF32 && sc != sp) return QNAN32;
      return {sp, INF32[30:0]};
    end
    if (ac == INF32) return c;
    if (aa == 0 || ab == 0) begin
      if (ac == 0) return {sp & sc, 31'b0};
      return c;
    end
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    x = ma * mb;
    ex = ea + eb;
    d = 61 - msb64(x);
    x = x << d;
    ex = ex - d;
    if (ac == 0) return fp_round(sp, x, ex);
    fp_split(c, mc, ec);
    d = 61 - msb64(mc);
    y = mc << d;
    ey = ec - d;
    sx = sp; sy = sc;
    if (ex < ey || (ex == ey && x < y)) begin
      t = x; te = ex; ts = sx;
      x = y; ex = ey; sx = sy;
      y = t; ey = te; sy = ts;
    end
    d = ex - ey;
    if (d >= 64) y = 64'd1;
    else if (d > 0) y = (y >> d) | 64'((y & ((64'd1 << d) - 64'd1)) != 0);
    s = (sx == sy) ? x + y : x - y;
    if (s == 0) return '0;
    return fp_round(sx, s, ex);
  endfunction

  function automatic word_t clamp_act(word_t v);
    word_t r;
    r = v;
    if (p_actv == ACTV_NONE) return r;
    if (r[30:0] > INF32[30:0] || r[31]) r = '0;
    if (p_actv[1] && r > SIX32) r = SIX32;
    return r;
  endfunction

  function automatic int eff_width();
    int w;
    w = int'(p_width);
    if (w < 1) w = 1;
    if (w > NPOS) w = NPOS;
    return w;
  endfunction

  function automatic bit lane_ready(logic [3:0] ln);
    logic [5:0] m;
    m = 6'((7'd1 << eff_width()) - 7'd1);
    return (written[ln] & m) == m;
  endfunction

  // updates the lane state; returns 1 with the finished word when one is due
  function automatic bit predict_word(action_e act, logic [3:0] ln, word_t wt,
                                      word_t v [NPOS], output fin_t f);
    int w;
    w = eff_width();
    f.lane = ln;
    for (int j = 0; j < NPOS; j++) f.res[j] = '0;
    case (act)
      ACT_START: begin
        for (int j = 0; j < w; j++) begin
          acc_mem[ln][j] = wt;
          written[ln][j] = 1'b1;
        end
      end
      ACT_ACCUM: begin
        for (int j = 0; j < w; j++) acc_mem[ln][j] = fp_fma(wt, v[j], acc_mem[ln][j]);
      end
      ACT_FINISH: begin
        for (int j = 0; j < w; j++) begin
          f.res[j] = acc_mem[ln][j];
          if (p_sum) f.res[j] = fp_fma(v[j], ONE32, f.res[j]);
          f.res[j] = clamp_act(f.res[j]);
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic push_word(action_e act, logic [3:0] ln, word_t wt, word_t v [NPOS],
                           bit typed = 1'b0, word_t tres [NPOS] = '{default: '0});
    fin_t f;
    @(negedge clk_i);
    while ($urandom_range(99) < sidle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    action_i <= act;
    lane_i <= ln;
    weight_i <= wt;
    for (int j = 0; j < NPOS; j++) value_w[j] <= v[j];
    do @(posedge clk_i); while (full);
    if (act == ACT_NONE) n_ignored++;
    else n_items++;
    if (predict_word(act, ln, wt, v, f)) begin
      if (typed) f.res = tres;
      pending_q.push_back(f);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [2:0] data);
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WIDTH: p_width = data;
      REG_SUM:   p_sum = data[0];
      REG_ACTV:  p_actv = data[1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic word_t rand_fp();
    word_t r;
    r = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: r[30:23] = 8'($urandom_range(118, 132));
      4:          r[30:23] = 8'd0;
      5:          r[30:23] = 8'($urandom_range(250, 254));
      6: begin
        case ($urandom_range(5))
          0: r = '0;
          1: r = 32'h8000_0000;
          2: r = INF32;
          3: r = NINF32;
          4: r = QNAN32 | 32'($urandom_range(1, 1000));
          default: r = 32'h7F7F_FFFF;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic rand_vals(output word_t v [NPOS]);
    for (int j = 0; j < NPOS; j++) v[j] = rand_fp();
  endtask

  task automatic run_chain(logic [3:0] ln);
    word_t v [NPOS];
    rand_vals(v);
    push_word(ACT_START, ln, rand_fp(), v);
    repeat ($urandom_range(0, 3)) begin
      rand_vals(v);
      push_word(ACT_ACCUM, ln, rand_fp(), v);
    end
    rand_vals(v);
    push_word(ACT_FINISH, ln, rand_fp(), v);
  endtask

  task automatic add_row(bit is_cfg, logic [1:0] idx, logic [2:0] data, action_e act,
                         logic [3:0] ln, word_t wt, word_t v [NPOS], bit typed,
                         word_t res [NPOS]);
    row_t r;
    r.is_cfg = is_cfg; r.idx = idx; r.data = data; r.act = act; r.lane = ln;
    r.wt = wt; r.vals = v; r.typed = typed; r.res = res;
    table_q.push_back(r);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    bit held;
    held = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (want_hold && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD - 1) @(negedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= ridle);
      end
    end
  end

  always @(posedge clk_i) begin
    fin_t  f;
    word_t got [NPOS];
    if (rst_ni && pop && !empty) begin
      got = '{result0_o, result1_o, result2_o, result3_o, result4_o, result5_o};
      n_words++;
      if (pending_q.size() == 0) begin
        $error("unexpected word for lane %0d", out_lane_o);
        errors++;
      end else begin
        f = pending_q.pop_front();
        if (out_lane_o !== f.lane) begin
          $error("out_lane expected %0d actual %0d", f.lane, out_lane_o);
          errors++;
        end
        for (int j = 0; j < NPOS; j++) begin
          if (got[j] !== f.res[j]) begin
            $error("result%0d expected %h actual %h", j, f.res[j], got[j]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    word_t z [NPOS];
    word_t v [NPOS];
    logic [3:0] ln;
    int r, cnt;
    static logic [2:0] cfg_w [5] = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd6};
    static logic       cfg_s [5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    static logic [1:0] cfg_a [5] = '{ACTV_RELU, ACTV_RELU6, 2'd3, ACTV_NONE, ACTV_RELU};
    static int         s_pct [4] = '{0, 58, 0, 6};
    static int         r_pct [4] = '{0, 0, 58, 6};

    z = '{default: '0};
    push = 1'b0; action_i = ACT_NONE; lane_i = '0; weight_i = '0;
    value_w = '{default: '0};
    cfg_valid_i = 1'b0; cfg_index_i = REG_WIDTH; cfg_data_i = WIDTH_RST;
    n_items = 0; n_cfg = 0; n_ignored = 0;
    sidle = 0; ridle = 0; want_hold = 1'b0;
    p_width = WIDTH_RST; p_sum = 1'b0; p_actv = ACTV_NONE;
    for (int i = 0; i < NLANES; i++) written[i] = '0;

    add_row(0, 0, 0, ACT_START, 4'd0, ONE32, z, 0, z);
    add_row(0, 0, 0, ACT_FINISH, 4'd0, '0, z, 1, '{default: ONE32});
    add_row(0, 0, 0, ACT_ACCUM, 4'd0, INF32,
            '{'0, ONE32, NINF32, 32'h7FFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001}, 0, z);
    add_row(0, 0, 0, ACT_FINISH, 4'd0, '0, z, 1,
            '{QNAN32, INF32, NINF32, QNAN32, INF32, INF32});
    add_row(0, 0, 0, ACT_START, 4'd15, 32'h8000_0000, z, 0, z);
    add_row(0, 0, 0, ACT_ACCUM, 4'd15, '0,
            '{'0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0080_0000, ONE32}, 0, z);
    add_row(0, 0, 0, ACT_NONE, 4'd15, 32'hFFFF_FFFF, '{default: 32'hFFFF_FFFF}, 0, z);
    add_row(0, 0, 0, ACT_FINISH, 4'd15, '0, z, 0, z);
    add_row(0, 0, 0, ACT_START, 4'd3, 32'h0000_0001, z, 0, z);
    add_row(0, 0, 0, ACT_ACCUM, 4'd3, 32'h7F7F_FFFF,
            '{32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0001, ONE32, 32'hFF7F_FFFF,
              32'h0040_0000}, 0, z);
    add_row(0, 0, 0, ACT_FINISH, 4'd3, '0, z, 0, z);
    add_row(1, REG_SUM, 3'd1, ACT_NONE, 0, '0, z, 0, z);
    add_row(1, REG_ACTV, 3'(ACTV_RELU6), ACT_NONE, 0, '0, z, 0, z);
    add_row(0, 0, 0, ACT_FINISH, 4'd0, '0, z, 1, '{'0, SIX32, '0, '0, SIX32, SIX32});
    add_row(0, 0, 0, ACT_FINISH, 4'd3, '0,
            '{32'h40E0_0000, 32'hC0E0_0000, 32'h3F80_0000, 32'h80000000, '0,
              32'h7F80_0001}, 0, z);
    add_row(1, REG_WIDTH, 3'd1, ACT_NONE, 0, '0, z, 0, z);
    add_row(1, REG_ACTV, 3'(ACTV_RELU), ACT_NONE, 0, '0, z, 0, z);
    add_row(0, 0, 0, ACT_START, 4'd7, 32'hBF80_0000, z, 0, z);
    add_row(0, 0, 0, ACT_FINISH, 4'd7, '0, z, 1, z);

    @(posedge rst_ni);
    foreach (table_q[i]) begin
      if (table_q[i].is_cfg)
        write_reg(table_q[i].idx, table_q[i].data);
      else
        push_word(table_q[i].act, table_q[i].lane, table_q[i].wt, table_q[i].vals,
                  table_q[i].typed, table_q[i].res);
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_WIDTH, cfg_w[ph]);
      write_reg(REG_SUM, {2'b0, cfg_s[ph]});
      write_reg(REG_ACTV, {1'b0, cfg_a[ph]});
      sidle = s_pct[ph % 4];
      ridle = r_pct[ph % 4];
      if (ph == 1) begin
        // long receive stall while finished words pile up
        want_hold = 1'b1;
        for (int k = 0; k < 8; k++) begin
          rand_vals(v);
          push_word(ACT_START, 4'(k), rand_fp(), v);
          push_word(ACT_FINISH, 4'(k), '0, v);
        end
      end
      cnt = n_items + 80;
      while (n_items < cnt) begin
        r = $urandom_range(99);
        ln = 4'($urandom_range(NLANES - 1));
        rand_vals(v);
        if (r < 8) push_word(ACT_NONE, ln, rand_fp(), v);
        else if (r < 16 && lane_ready(ln)) push_word(ACT_FINISH, ln, '0, v);
        else if (r < 22 && lane_ready(ln)) push_word(ACT_ACCUM, ln, rand_fp(), v);
        else run_chain(ln);
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d finished words never arrived", pending_q.size());
    end
    $display("covered %0d items (%0d ignored), %0d output words, %0d register writes",
             n_items, n_ignored, n_words, n_cfg);
    $display("five register settings, four idling patterns, one long output stall");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
